// ===== sv/twpc_pkg.sv =====
// Shared types and constants of the triangle window polygon clipper.
// No dependencies; imported by twpc_ifs, twpc_cell and the top level.
package twpc_pkg;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIN_AX = 3'd0,
        CFG_WIN_AY = 3'd1,
        CFG_WIN_BX = 3'd2,
        CFG_WIN_BY = 3'd3,
        CFG_WIN_CX = 3'd4,
        CFG_WIN_CY = 3'd5
    } t_cfg_idx;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_D1     = 11'b00000000010,
        S_D2     = 11'b00000000100,
        S_SETUP  = 11'b00000001000,
        S_DSTART = 11'b00000010000,
        S_DIV    = 11'b00000100000,
        S_RND    = 11'b00001000000,
        S_EMITC  = 11'b00010000000,
        S_EMITQ  = 11'b00100000000,
        S_NEXT   = 11'b01000000000,
        S_FIN    = 11'b10000000000
    } t_cell_state;

endpackage

// ===== sv/twpc_ifs.sv =====
// Valid/ready channel interfaces: vertex input, clipped item stream, configuration.
// Depends on twpc_pkg for the configuration index width.
interface twpc_vtx_if #(parameter int W = 12);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] vertex_x;
    logic signed [W-1:0] vertex_y;
    logic                last_vertex;
    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface twpc_item_if #(parameter int W = 12);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_x;
    logic signed [W-1:0] out_y;
    logic                is_vertex;
    logic                out_last;
    modport source (output valid, out_x, out_y, is_vertex, out_last, input ready);
    modport sink   (input valid, out_x, out_y, is_vertex, out_last, output ready);
endinterface

interface twpc_cfg_if import twpc_pkg::*; #(parameter int W = 12);
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [W-1:0]            data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/twpc_divider.sv =====
// Bit-serial scaled divider: computes k*u/dm and its remainder, one bit of k a cycle.
// Standalone; used by twpc_cell.
module twpc_divider #(
    parameter int W = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_k,
    input  logic [2*W+3:0] i_u,
    input  logic [2*W+3:0] i_dm,
    output logic           o_done,
    output logic [W-1:0]   o_qt,
    output logic [2*W+3:0] o_rem
);
    localparam int DW = 2*W+4;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_k;
    logic [W-1:0]  r_qt;
    logic [DW-1:0] r_rem;
    logic [DW:0]   w_r;
    logic [W-1:0]  w_q;

    always_comb begin
        w_r = {r_rem, 1'b0};
        w_q = {r_qt[W-2:0], 1'b0};
        if (w_r >= {1'b0, i_dm}) begin
            w_r = w_r - {1'b0, i_dm};
            w_q = w_q + 1'b1;
        end
        if (r_k[r_cnt]) begin
            w_r = w_r + {1'b0, i_u};
            if (w_r >= {1'b0, i_dm}) begin
                w_r = w_r - {1'b0, i_dm};
                w_q = w_q + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W-1);
                r_k    <= i_k;
                r_qt   <= '0;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_qt  <= w_q;
                r_rem <= w_r[DW-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_qt   = r_qt;
    assign o_rem  = r_rem;
endmodule

// ===== sv/twpc_cell.sv =====
// One clipping cell: clips the item stream against a single window edge.
// Depends on twpc_pkg, twpc_ifs and twpc_divider.
module twpc_cell import twpc_pkg::*; #(
    parameter int W = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic signed [W-1:0] i_ax,
    input  logic signed [W-1:0] i_ay,
    input  logic signed [W-1:0] i_bx,
    input  logic signed [W-1:0] i_by,
    twpc_item_if.sink           i_in,
    twpc_item_if.source         o_out
);
    localparam int FW = 2*W+3;
    localparam int DW = 2*W+4;
    localparam logic signed [W+1:0] ONE = 1;

    t_cell_state n_state, r_state;

    logic signed [W-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y, r_pend_x, r_pend_y;
    logic signed [W-1:0] r_px, r_py, r_qx, r_qy, r_cx, r_cy, r_bp;
    logic                r_have_first, r_emitted, r_l, r_closing, r_in2, r_axis_y, r_s;
    logic signed [FW-1:0] r_d1, r_d2;
    logic [DW-1:0]       r_u, r_dm;
    logic                r_ovalid, r_ov, r_ol;
    logic signed [W-1:0] r_ox, r_oy;

    logic signed [W-1:0]   w_sx, w_sy, w_pp, w_qq, w_res;
    logic signed [W:0]     w_ex, w_ey, w_eab, w_eba, w_dif;
    logic signed [2*W+1:0] w_p1, w_p2;
    logic signed [FW-1:0]  w_fn;
    logic signed [DW-1:0]  w_den;
    logic [DW-1:0]         w_u, w_dm, w_rem;
    logic [W-1:0]          w_k, w_qt;
    logic                  w_in1, w_in2, w_out_free, w_emit_ok, w_div_done, w_load;
    logic signed [W+1:0]   w_qext, w_base, w_rnd;
    logic [DW:0]           w_tw;
    logic                  w_gt, w_eq;

    assign w_sx  = (r_state == S_D2) ? r_qx : r_px;
    assign w_sy  = (r_state == S_D2) ? r_qy : r_py;
    assign w_ex  = (W+1)'(w_sx) - (W+1)'(i_ax);
    assign w_ey  = (W+1)'(w_sy) - (W+1)'(i_ay);
    assign w_eab = (W+1)'(i_ay) - (W+1)'(i_by);
    assign w_eba = (W+1)'(i_bx) - (W+1)'(i_ax);
    assign w_p1  = w_ex * w_eab;
    assign w_p2  = w_ey * w_eba;
    assign w_fn  = FW'(w_p1) + FW'(w_p2);

    assign w_in1 = r_d1[FW-1] || (r_d1 == '0);
    assign w_in2 = r_d2[FW-1] || (r_d2 == '0);
    assign w_den = DW'(r_d1) - DW'(r_d2);
    assign w_u   = DW'(r_d1[FW-1] ? -r_d1 : r_d1);
    assign w_dm  = w_den[DW-1] ? -w_den : w_den;

    assign w_pp  = r_axis_y ? r_py : r_px;
    assign w_qq  = r_axis_y ? r_qy : r_qx;
    assign w_dif = (W+1)'(w_qq) - (W+1)'(w_pp);
    assign w_k   = W'(w_dif[W] ? -w_dif : w_dif);

    twpc_divider #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_k     (w_k),
        .i_u     (r_u),
        .i_dm    (r_dm),
        .o_done  (w_div_done),
        .o_qt    (w_qt),
        .o_rem   (w_rem)
    );

    assign w_qext = (W+2)'($signed({1'b0, w_qt}));
    assign w_base = (W+2)'(r_bp) + (r_s ? -w_qext : w_qext);
    assign w_tw   = {w_rem, 1'b0};
    assign w_gt   = w_tw > {1'b0, r_dm};
    assign w_eq   = w_tw == {1'b0, r_dm};

    always_comb begin
        w_rnd = w_base;
        if (w_gt) begin
            w_rnd = r_s ? w_base - ONE : w_base + ONE;
        end else if (w_eq) begin
            if (!r_s) begin
                w_rnd = w_base[W+1] ? w_base : w_base + ONE;
            end else begin
                w_rnd = (!w_base[W+1] && w_base != '0) ? w_base : w_base - ONE;
            end
        end
    end
    assign w_res = w_rnd[W-1:0];

    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_emit_ok  = !r_emitted || w_out_free;
    assign w_load     = ((r_state inside {S_EMITC, S_EMITQ}) && w_emit_ok && r_emitted) ||
                        (r_state == S_FIN && w_out_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.is_vertex) begin
                        n_state = (r_have_first || i_in.out_last) ? S_D1 : S_IDLE;
                    end else if (i_in.out_last) begin
                        n_state = r_have_first ? S_D1 : S_FIN;
                    end
                end
            end
            S_D1:     n_state = S_D2;
            S_D2:     n_state = S_SETUP;
            S_SETUP: begin
                if (w_in1 != w_in2) n_state = S_DSTART;
                else if (w_in2)     n_state = S_EMITQ;
                else                n_state = S_NEXT;
            end
            S_DSTART: n_state = S_DIV;
            S_DIV:    n_state = w_div_done ? S_RND : S_DIV;
            S_RND:    n_state = r_axis_y ? S_EMITC : S_DSTART;
            S_EMITC: begin
                if (w_emit_ok) n_state = r_in2 ? S_EMITQ : S_NEXT;
            end
            S_EMITQ: begin
                if (w_emit_ok) n_state = S_NEXT;
            end
            S_NEXT: begin
                if (!r_closing && r_l) n_state = S_D1;
                else if (r_closing)    n_state = S_FIN;
                else                   n_state = S_IDLE;
            end
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_have_first <= 1'b0;
            r_emitted    <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_l <= i_in.out_last;
                        if (i_in.is_vertex) begin
                            r_prev_x <= i_in.out_x;
                            r_prev_y <= i_in.out_y;
                            r_qx     <= i_in.out_x;
                            r_qy     <= i_in.out_y;
                            if (r_have_first) begin
                                r_px      <= r_prev_x;
                                r_py      <= r_prev_y;
                                r_closing <= 1'b0;
                            end else begin
                                r_first_x    <= i_in.out_x;
                                r_first_y    <= i_in.out_y;
                                r_have_first <= 1'b1;
                                r_px         <= i_in.out_x;
                                r_py         <= i_in.out_y;
                                r_closing    <= 1'b1;
                            end
                        end else begin
                            r_px      <= r_prev_x;
                            r_py      <= r_prev_y;
                            r_qx      <= r_first_x;
                            r_qy      <= r_first_y;
                            r_closing <= 1'b1;
                        end
                    end
                end
                S_D1: r_d1 <= w_fn;
                S_D2: r_d2 <= w_fn;
                S_SETUP: begin
                    r_in2    <= w_in2;
                    r_u      <= w_u;
                    r_dm     <= w_dm;
                    r_axis_y <= 1'b0;
                end
                S_DSTART: begin
                    r_s  <= w_dif[W];
                    r_bp <= w_pp;
                end
                S_RND: begin
                    if (r_axis_y) begin
                        r_cy <= w_res;
                    end else begin
                        r_cx <= w_res;
                    end
                    r_axis_y <= 1'b1;
                end
                S_EMITC, S_EMITQ: begin
                    if (w_emit_ok) begin
                        if (r_emitted) begin
                            r_ox     <= r_pend_x;
                            r_oy     <= r_pend_y;
                            r_ov     <= 1'b1;
                            r_ol     <= 1'b0;
                        end
                        r_pend_x  <= (r_state == S_EMITC) ? r_cx : r_qx;
                        r_pend_y  <= (r_state == S_EMITC) ? r_cy : r_qy;
                        r_emitted <= 1'b1;
                    end
                end
                S_NEXT: begin
                    if (!r_closing && r_l) begin
                        r_px      <= r_prev_x;
                        r_py      <= r_prev_y;
                        r_qx      <= r_first_x;
                        r_qy      <= r_first_y;
                        r_closing <= 1'b1;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ox         <= r_emitted ? r_pend_x : '0;
                        r_oy         <= r_emitted ? r_pend_y : '0;
                        r_ov         <= r_emitted;
                        r_ol         <= 1'b1;
                        r_emitted    <= 1'b0;
                        r_have_first <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.out_x     = r_ox;
    assign o_out.out_y     = r_oy;
    assign o_out.is_vertex = r_ov;
    assign o_out.out_last  = r_ol;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV) else $error("divider finished outside S_DIV");
    a_cross_sides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DSTART |-> w_in1 != w_in2) else $error("crossing without side change");
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_ov |-> r_ol) else $error("empty word not marked last");
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && w_out_free |=> !r_emitted && !r_have_first)
        else $error("polygon state not cleared after close");
endmodule

// ===== sv/triangle_window_polygon_clipper.sv =====
// Top level of the triangle window polygon clipper: configuration registers and
// a chain of three clipping cells. Depends on twpc_pkg, twpc_ifs and twpc_cell.
//
// Usage: vertices enter on i_vtx one word at a time; last_vertex closes the polygon.
// Clipped vertices leave on o_res; out_last marks the final word of a polygon, and
// a polygon clipped away entirely yields one word with is_vertex low and out_last
// high. The window corners A, B, C are written on i_cfg (index 0..5 = ax, ay, bx,
// by, cx, cy; other indexes are ignored) while no polygon is in flight; i_cfg is
// always ready.
// Rate: each cell takes one word at a time and accepts no new word until it has
// finished the edge of the last one. An edge with no crossing is quickest, a kept
// end vertex adds an emit step, and a crossing adds a division per coordinate in
// the cell's bit-serial divider; a closing vertex runs the closing edge as well. The
// cells run concurrently, so sustained throughput is set by the busiest cell, and a
// closing vertex whose edges all cross can hold the chain while its burst of words
// passes. Results of a vertex may appear as late as the last vertex of its polygon.
// Reset (synchronous, active low) loads the default window and empties all cells.
// A stall on o_res holds the last cell's output register; back-pressure then
// reaches i_vtx through the chain, and no word is lost.
module triangle_window_polygon_clipper import twpc_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    twpc_vtx_if.sink    i_vtx,
    twpc_item_if.source o_res,
    twpc_cfg_if.sink    i_cfg
);
    localparam int W = COORD_BITS;

    logic signed [W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;

    twpc_item_if #(.W(W)) w_s0 ();
    twpc_item_if #(.W(W)) w_s1 ();
    twpc_item_if #(.W(W)) w_s2 ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= W'(40);
            r_ay <= W'(200);
            r_bx <= W'(300);
            r_by <= W'(240);
            r_cx <= W'(140);
            r_cy <= W'(40);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_WIN_AX: r_ax <= i_cfg.data;
                CFG_WIN_AY: r_ay <= i_cfg.data;
                CFG_WIN_BX: r_bx <= i_cfg.data;
                CFG_WIN_BY: r_by <= i_cfg.data;
                CFG_WIN_CX: r_cx <= i_cfg.data;
                CFG_WIN_CY: r_cy <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    assign w_s0.valid     = i_vtx.valid;
    assign w_s0.out_x     = i_vtx.vertex_x;
    assign w_s0.out_y     = i_vtx.vertex_y;
    assign w_s0.is_vertex = 1'b1;
    assign w_s0.out_last  = i_vtx.last_vertex;
    assign i_vtx.ready    = w_s0.ready;

    twpc_cell #(.W(W)) u_cell_ab (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_ax (r_ax), .i_ay (r_ay), .i_bx (r_bx), .i_by (r_by),
        .i_in (w_s0), .o_out (w_s1)
    );

    twpc_cell #(.W(W)) u_cell_bc (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_ax (r_bx), .i_ay (r_by), .i_bx (r_cx), .i_by (r_cy),
        .i_in (w_s1), .o_out (w_s2)
    );

    twpc_cell #(.W(W)) u_cell_ca (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_ax (r_cx), .i_ay (r_cy), .i_bx (r_ax), .i_by (r_ay),
        .i_in (w_s2), .o_out (o_res)
    );
endmodule
